// ===== rtl/emrc_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the exact-match route table.
// No dependencies; imported by every other file of the block.
package emrc_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0] ENTRIES_C = CNT_W'(ENTRIES);

  localparam logic KIND_ADD    = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic match;
    logic exhausted;
  } status_t;

endpackage

// ===== rtl/emrc_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the route table.
// Depends on emrc_pkg for the state encoding and the command and status structs.
module emrc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  emrc_pkg::status_t sts,
  output emrc_pkg::cmd_t    cmd
);
  import emrc_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    busy       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        busy       = 1'b1;
        cmd.finish = sts.match || sts.exhausted;
        cmd.scan   = !cmd.finish;
        if (cmd.finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A finish can only be issued while a search is running.
  a_finish_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> state_r == ST_SCAN)
    else $error("finish issued outside a search");

  // An accepted transaction always starts a search on the next cycle.
  a_load_to_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> busy)
    else $error("accepted transaction did not start a search");

endmodule

// ===== rtl/emrc_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the route table: key and port memories, fill count, scan pointer,
// compare stage and result registers. Depends on emrc_pkg.
module emrc_datapath (
  input  logic                     clk,
  input  logic                     rst_n,
  input  emrc_pkg::cmd_t           cmd,
  output emrc_pkg::status_t        sts,
  input  logic                     in_kind,
  input  logic [31:0]              in_address,
  input  logic [7:0]               in_port,
  output logic                     out_valid,
  output logic                     out_hit,
  output logic [7:0]               out_port_out,
  output logic                     out_table_full
);
  import emrc_pkg::*;

  logic [31:0] key_mem  [ENTRIES];
  logic [7:0]  port_mem [ENTRIES];

  logic             kind_r;
  logic [31:0]      addr_r;
  logic [7:0]       port_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [31:0]      key_q_r;
  logic [7:0]       port_q_r;
  logic [IDX_W-1:0] q_idx_r;
  logic             q_vld_r, q_vld_nxt;
  logic             rd_fire;
  logic             key_wr, port_wr;
  logic [IDX_W-1:0] wr_addr;
  logic             res_hit, res_full;
  logic [7:0]       res_port;

  // Valid entries always occupy indexes below the fill count.
  assign rd_fire       = cmd.scan && (rd_idx_r < count_r);
  assign sts.match     = q_vld_r && (key_q_r == addr_r);
  assign sts.exhausted = !q_vld_r && (rd_idx_r >= count_r);

  always_comb begin
    key_wr   = 1'b0;
    port_wr  = 1'b0;
    wr_addr  = q_idx_r;
    res_hit  = sts.match;
    res_port = 8'd0;
    res_full = 1'b0;
    if (kind_r == KIND_ADD) begin
      if (sts.match) begin
        port_wr = cmd.finish;
      end else if (count_r < ENTRIES_C) begin
        key_wr  = cmd.finish;
        port_wr = cmd.finish;
        wr_addr = count_r[IDX_W-1:0];
      end else begin
        res_full = 1'b1;
      end
    end else if (sts.match) begin
      res_port = port_q_r;
    end
  end

  always_comb begin
    count_nxt  = key_wr ? count_r + CNT_W'(1) : count_r;
    rd_idx_nxt = cmd.load ? '0 : (rd_fire ? rd_idx_r + CNT_W'(1) : rd_idx_r);
    q_vld_nxt  = cmd.load ? 1'b0 : rd_fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      rd_idx_r  <= '0;
      q_vld_r   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      rd_idx_r  <= rd_idx_nxt;
      q_vld_r   <= q_vld_nxt;
      out_valid <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      addr_r <= in_address;
      port_r <= in_port;
    end
    if (cmd.finish) begin
      out_hit        <= res_hit;
      out_port_out   <= res_port;
      out_table_full <= res_full;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_fire) begin
      key_q_r  <= key_mem[rd_idx_r[IDX_W-1:0]];
      port_q_r <= port_mem[rd_idx_r[IDX_W-1:0]];
      q_idx_r  <= rd_idx_r[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (key_wr) begin
      key_mem[wr_addr] <= addr_r;
    end
    if (port_wr) begin
      port_mem[wr_addr] <= port_r;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ENTRIES_C)
    else $error("fill count exceeds table size");

  a_result_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(cmd.finish))
    else $error("result strobe without a finished search");

  a_full_not_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_full |-> !out_hit && out_port_out == 8'd0)
    else $error("dropped add reported a hit or a port");

  a_port_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_port_out != 8'd0 |-> out_hit)
    else $error("nonzero port without a hit");

endmodule

// ===== rtl/exact_match_route_cam.sv =====
`timescale 1ns / 1ps
// Top level of the exact-match IPv4 route table: controller plus datapath.
// Depends on emrc_pkg, emrc_ctrl and emrc_datapath.
//
// The table holds up to ENTRIES address-to-port mappings (64 as shipped) and is
// empty after reset. A transaction is accepted on a rising edge with start high
// and busy low; in_kind selects add/update or lookup. Entries fill from index
// zero upward and are never removed, so the search walks the filled entries
// one per cycle through a single read port on the key and port memories, with
// the read data registered in front of the compare. A transaction that
// matches the entry at index i holds busy until that entry has been read and
// compared. A transaction that finds no match holds busy until every filled
// entry has been compared, and a search of a still empty table ends as soon
// as it starts. The accepting cycle itself has busy low, before the search
// begins. The result strobe out_valid rises in the first cycle
// after the search, when busy is low again, and lasts exactly one cycle; the
// receiver cannot stall it, so sample out_hit, out_port_out and
// out_table_full on that cycle. Because the result sits in its own register,
// a new transaction may be accepted in the same cycle the previous result is
// presented. An add of a new address to a full table leaves the table
// untouched and reports out_table_full. An add that updates an existing
// address reports out_hit with out_port_out at zero.
module exact_match_route_cam (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_kind,
  input  logic [31:0] in_address,
  input  logic [7:0]  in_port,
  output logic        out_valid,
  output logic        out_hit,
  output logic [7:0]  out_port_out,
  output logic        out_table_full
);
  import emrc_pkg::*;

  cmd_t    cmd;
  status_t sts;

  // The controller sequences accept, search and finish.
  emrc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // The datapath holds the table and produces the result transaction.
  emrc_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_kind        (in_kind),
    .in_address     (in_address),
    .in_port        (in_port),
    .out_valid      (out_valid),
    .out_hit        (out_hit),
    .out_port_out   (out_port_out),
    .out_table_full (out_table_full)
  );

endmodule

// ===== test/exact_match_route_cam_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for exact_match_route_cam: directed and random adds and lookups,
// scored against a behavioral copy of the route table. Depends on emrc_pkg and the RTL.
module exact_match_route_cam_test;
  import emrc_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 8;
  // The slowest transaction is a miss on a full table.
  // Seven hundred of those plus sender gaps stay far below this limit.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 2 * ENTRIES + 8;
  localparam int POOL_SIZE    = 100;
  localparam int MAX_PRINTED  = 40;

  // One pending command for the driver. The idle percentage travels with the
  // command, so each phase carries its own sender gap rate.
  typedef struct {
    logic        kind;
    logic [31:0] address;
    logic [7:0]  port;
    int          idle_pct;
  } route_cmd_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] port_out;
    logic       table_full;
  } route_result_t;

  // Clock, reset and DUT ports. Every input starts at a known value.
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        in_kind = KIND_ADD;
  logic [31:0] in_address = '0;
  logic [7:0]  in_port = '0;
  logic        busy;
  logic        out_valid;
  logic        out_hit;
  logic [7:0]  out_port_out;
  logic        out_table_full;

  // Shadow copy of the route table, updated as each transaction is accepted.
  logic        route_valid [ENTRIES];
  logic [31:0] route_key [ENTRIES];
  logic [7:0]  route_port [ENTRIES];

  route_cmd_t    cmd_queue[$];
  route_result_t pending_results[$];
  logic [31:0]   addr_pool [POOL_SIZE];

  // Set at the rising edge that accepts a transaction, read by the driver at
  // the following falling edge to decide whether to move on.
  logic took = 1'b0;

  int cmds_queued = 0;
  int results_seen = 0;
  int errors = 0;
  int cycle_count = 0;
  int n_adds = 0;
  int n_lookups = 0;
  int n_lookup_hits = 0;
  int n_updates = 0;
  int n_dropped = 0;
  int n_idle_gaps = 0;

  exact_match_route_cam u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_address     (in_address),
    .in_port        (in_port),
    .out_valid      (out_valid),
    .out_hit        (out_hit),
    .out_port_out   (out_port_out),
    .out_table_full (out_table_full)
  );

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  // Works out the result of one transaction and applies it to the shadow
  // table. An add first looks for the address; on a match only the port
  // changes, otherwise the lowest free entry is taken, and with no free
  // entry the add is dropped and flagged. A lookup never touches the table.
  function automatic route_result_t predict_route(logic kind, logic [31:0] address,
                                                  logic [7:0] port);
    int found;
    int free_slot;
    route_result_t res;
    found = -1;
    free_slot = -1;
    res = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (route_valid[i] && route_key[i] == address && found < 0) found = i;
      if (!route_valid[i] && free_slot < 0) free_slot = i;
    end
    if (kind == KIND_ADD) begin
      n_adds++;
      if (found >= 0) begin
        route_port[found] = port;
        res.hit = 1'b1;
        n_updates++;
      end else if (free_slot >= 0) begin
        route_valid[free_slot] = 1'b1;
        route_key[free_slot] = address;
        route_port[free_slot] = port;
      end else begin
        res.table_full = 1'b1;
        n_dropped++;
      end
    end else begin
      n_lookups++;
      // A miss reports all zeros.
      if (found >= 0) begin
        res.hit = 1'b1;
        res.port_out = route_port[found];
        n_lookup_hits++;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    if (errors <= MAX_PRINTED)
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  task automatic queue_cmd(logic kind, logic [31:0] address, logic [7:0] port, int idle_pct);
    route_cmd_t c;
    c.kind = kind;
    c.address = address;
    c.port = port;
    c.idle_pct = idle_pct;
    cmd_queue.push_back(c);
    cmds_queued++;
  endtask

  // Most addresses come from the pool so that lookups hit and adds update.
  // Some are one bit away from a pool address, to catch a partial compare,
  // and the rest are fully random and nearly always miss.
  function automatic logic [31:0] pick_address(int span);
    int r;
    logic [31:0] a;
    r = $urandom_range(99);
    a = addr_pool[$urandom_range(span - 1)];
    if (r < 70) return a;
    if (r < 85) return a ^ (32'd1 << $urandom_range(31));
    return $urandom;
  endfunction

  task automatic queue_random(int count, int span, int add_pct, int idle_pct);
    logic        kind;
    logic [7:0]  port;
    int          r;
    for (int n = 0; n < count; n++) begin
      kind = ($urandom_range(99) < add_pct) ? KIND_ADD : KIND_LOOKUP;
      r = $urandom_range(99);
      port = (r < 10) ? 8'h00 : (r < 20) ? 8'hFF : 8'($urandom_range(255));
      queue_cmd(kind, pick_address(span), port, idle_pct);
    end
  endtask

  // A phase is finished once every queued command has produced its result.
  // The counters are only written at rising edges, so the check at the
  // falling edge sees settled values.
  task automatic wait_drained();
    while (results_seen < cmds_queued) @(negedge clk);
  endtask

  // Driver. Inputs change only at the falling edge. A command stays on the
  // ports until the rising edge that accepts it; only then does the driver
  // choose between the next command and an idle cycle.
  always @(negedge clk) begin
    route_cmd_t c;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (cmd_queue.size() > 0 && $urandom_range(99) >= cmd_queue[0].idle_pct) begin
        c = cmd_queue.pop_front();
        start <= 1'b1;
        in_kind <= c.kind;
        in_address <= c.address;
        in_port <= c.port;
      end else begin
        if (cmd_queue.size() > 0) n_idle_gaps++;
        start <= 1'b0;
      end
    end
  end

  // Monitor and scoreboard. The result strobe is checked before the new
  // transaction is predicted, since a result seen at this edge always
  // belongs to an earlier transaction.
  always @(posedge clk) begin
    route_result_t want;
    took <= rst_n && start && !busy;
    if (rst_n) begin
      if (out_valid) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing expected", 1, 0);
        end else begin
          want = pending_results.pop_front();
          if (out_hit !== want.hit) report_mismatch("out_hit", out_hit, want.hit);
          if (out_port_out !== want.port_out)
            report_mismatch("out_port_out", out_port_out, want.port_out);
          if (out_table_full !== want.table_full)
            report_mismatch("out_table_full", out_table_full, want.table_full);
        end
      end
      if (start && !busy)
        pending_results.push_back(predict_route(in_kind, in_address, in_port));
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               cmds_queued - results_seen);
      $display("exact_match_route_cam_test NOT OK");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      route_valid[i] = 1'b0;
      route_key[i] = '0;
      route_port[i] = '0;
    end
    // The pool mixes two dense subnets with scattered addresses. It holds
    // more addresses than the table has entries, so later phases fill it.
    for (int i = 0; i < POOL_SIZE; i++) begin
      case (i % 3)
        0: addr_pool[i] = {8'd10, 24'($urandom)};
        1: addr_pool[i] = {8'd192, 8'd168, 16'($urandom)};
        default: addr_pool[i] = $urandom;
      endcase
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty-table misses, both address extremes, updates
    // that rewrite the port, lookups with the port field set (it must be
    // ignored), and near misses one bit away from stored keys.
    queue_cmd(KIND_LOOKUP, 32'h0000_0000, 8'h00, 0);
    queue_cmd(KIND_LOOKUP, 32'hFFFF_FFFF, 8'hFF, 0);
    queue_cmd(KIND_ADD,    32'h0000_0000, 8'h00, 0);
    queue_cmd(KIND_ADD,    32'hFFFF_FFFF, 8'hFF, 0);
    queue_cmd(KIND_LOOKUP, 32'h0000_0000, 8'hFF, 0);
    queue_cmd(KIND_LOOKUP, 32'hFFFF_FFFF, 8'h00, 0);
    queue_cmd(KIND_ADD,    32'h0000_0000, 8'hA5, 0);
    queue_cmd(KIND_LOOKUP, 32'h0000_0000, 8'h00, 0);
    queue_cmd(KIND_LOOKUP, 32'h0000_0001, 8'h00, 0);
    queue_cmd(KIND_LOOKUP, 32'h8000_0000, 8'h00, 0);
    queue_cmd(KIND_ADD,    32'h8000_0000, 8'h01, 0);
    queue_cmd(KIND_ADD,    32'h7FFF_FFFF, 8'h80, 0);
    queue_cmd(KIND_ADD,    32'hFFFF_FFFF, 8'h00, 0);
    queue_cmd(KIND_LOOKUP, 32'hFFFF_FFFF, 8'hFF, 0);
    queue_cmd(KIND_LOOKUP, 32'h7FFF_FFFF, 8'h00, 0);
    queue_cmd(KIND_LOOKUP, 32'h8000_0000, 8'hFF, 0);
    queue_cmd(KIND_ADD,    32'h8000_0000, 8'h5A, 0);
    queue_cmd(KIND_LOOKUP, 32'h8000_0000, 8'h00, 0);
    queue_cmd(KIND_LOOKUP, 32'h7FFF_FFFE, 8'h00, 0);
    queue_cmd(KIND_LOOKUP, 32'hFFFF_FFFE, 8'h00, 0);
    wait_drained();

    // Random phases. The first keeps to part of the pool and runs back-to-back
    // transactions without gaps. The later ones draw on the whole pool, which
    // overflows the table and exercises dropped adds, with frequent and then
    // moderate sender gaps.
    @(posedge clk);
    queue_random(240, 40, 50, 0);
    wait_drained();
    @(posedge clk);
    queue_random(220, POOL_SIZE, 55, 63);
    wait_drained();
    @(posedge clk);
    queue_random(220, POOL_SIZE, 50, 22);
    wait_drained();

    // Let any stray result show up before closing the books.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", 0, pending_results.size());

    $display("covered %0d adds (%0d updates, %0d dropped on a full table) and %0d lookups",
             n_adds, n_updates, n_dropped, n_lookups);
    $display("%0d lookups hit, %0d sender idle cycles, %0d mismatches",
             n_lookup_hits, n_idle_gaps, errors);
    if (errors == 0) begin
      $display("exact_match_route_cam_test OK");
    end else begin
      $display("exact_match_route_cam_test NOT OK");
    end
    $finish;
  end

endmodule
